// ===== hdl/svim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svim_pkg: shared types and constants of the strided view index mapper
// Table sizes, action codes, controller states and the divider cell payload.
// ----------------------------------------------------------------------------
package svim_pkg;

  localparam int unsigned MAX_AXES  = 4;
  localparam int unsigned MAX_VIEWS = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned AXIS_W    = $clog2(MAX_AXES);
  localparam int unsigned SLOT_W    = $clog2(MAX_VIEWS);
  localparam int unsigned ENTRY_W   = AXIS_W + SLOT_W;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_AXIS  = 2'd1,
    ACT_VIEW  = 2'd2,
    ACT_SPARE = 2'd3
  } action_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_VIEW = 7'b0000010,
    ST_AXIS = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_NEXT = 7'b1000000
  } state_e;

  // One restoring-division step travels from cell to cell in this form.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] dvs;
  } div_t;

endpackage

// ===== hdl/svim_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svim_ifs: channel interfaces of the strided view index mapper
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface svim_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  view_slot;
  logic [1:0]  axis;
  logic [31:0] dim_value;
  logic signed [31:0] stride_value;
  logic signed [31:0] offset_value;
  logic        contiguous_value;
  logic [2:0]  axis_total;
  logic [31:0] flat_index;
  modport source (output valid, action, view_slot, axis, dim_value, stride_value,
                  offset_value, contiguous_value, axis_total, flat_index,
                  input ready);
  modport sink (input valid, action, view_slot, axis, dim_value, stride_value,
                offset_value, contiguous_value, axis_total, flat_index,
                output ready);
endinterface

interface svim_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] buffer_index;
  modport source (output valid, buffer_index, input ready);
  modport sink (input valid, buffer_index, output ready);
endinterface

interface svim_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/svim_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svim_div_cell: one stage of the restoring divider chain
// Shifts one dividend bit into the partial remainder and subtracts if it fits.
// ----------------------------------------------------------------------------
module svim_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  svim_pkg::div_t   cell_i,
  output svim_pkg::div_t   cell_o
);

  logic [svim_pkg::WORD_W:0]   trial;
  logic [svim_pkg::WORD_W:0]   diff;
  logic                        fits;
  logic [svim_pkg::WORD_W-1:0] rem_d, quo_d;
  logic                        valid_q;
  logic [svim_pkg::WORD_W-1:0] rem_q, quo_q, dvs_q;

  always_comb begin
    trial = {cell_i.rem, cell_i.quo[svim_pkg::WORD_W-1]};
    diff  = trial - {1'b0, cell_i.dvs};
    fits  = ~diff[svim_pkg::WORD_W];
    rem_d = fits ? diff[svim_pkg::WORD_W-1:0] : trial[svim_pkg::WORD_W-1:0];
    quo_d = {cell_i.quo[svim_pkg::WORD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= cell_i.dvs;
  end

  assign cell_o = '{valid: valid_q, rem: rem_q, quo: quo_q, dvs: dvs_q};

endmodule

// ===== hdl/strided_view_index_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_view_index_mapper: flat index to buffer index through strided views
// Descriptor tables, a sequencing controller and a 32-cell divider chain.
// ----------------------------------------------------------------------------
// A descriptor write is taken in the idle state and leaves the block ready.
// A map transaction walks view slot 0 and then slots 1..prior_view_count one
// at a time: a contiguous view goes from the view state straight to the NEXT
// state; a strided view steps the axis state past each zero-extent axis and,
// per used axis, launches a division, waits for the trip through the divider
// cell chain (one quotient bit per cell), then multiplies and accumulates.
// The result sits in an output register, so a new transaction is taken while
// the previous result waits.
module strided_view_index_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  svim_in_if.sink            in_i,
  svim_out_if.source         out_o,
  svim_cfg_if.sink           cfg_i
);

  localparam int unsigned W = svim_pkg::WORD_W;

  svim_pkg::state_e state_q, state_d;

  logic [W-1:0] dim_q    [svim_pkg::MAX_VIEWS*svim_pkg::MAX_AXES];
  logic [W-1:0] stride_q [svim_pkg::MAX_VIEWS*svim_pkg::MAX_AXES];
  logic [W-1:0] offset_q [svim_pkg::MAX_VIEWS];
  logic         contig_q [svim_pkg::MAX_VIEWS];
  logic [2:0]   count_q  [svim_pkg::MAX_VIEWS];

  logic [1:0]   pvc_q;
  logic [W-1:0] idx_q, acc_q, strd_q, coord_q, prod_q, res_q;
  logic [svim_pkg::SLOT_W-1:0] slot_q;
  logic [svim_pkg::AXIS_W:0]   ax_q;
  logic         out_valid_q;

  logic                          in_hs;
  logic [svim_pkg::AXIS_W:0]     ax_m1;
  logic [svim_pkg::ENTRY_W-1:0]  entry;
  logic [svim_pkg::ENTRY_W-1:0]  wr_entry;
  logic [W-1:0]                  cur_dim;
  logic [2:0]                    cur_cnt;
  logic                          out_free;

  svim_pkg::div_t chain [svim_pkg::DIV_STEPS+1];
  logic [svim_pkg::DIV_STEPS:0] chain_valid;

  assign in_hs     = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == svim_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free  = ~out_valid_q | out_o.ready;

  assign ax_m1    = ax_q - 1'b1;
  assign entry    = {slot_q, ax_m1[svim_pkg::AXIS_W-1:0]};
  assign wr_entry = {in_i.view_slot[svim_pkg::SLOT_W-1:0], in_i.axis[svim_pkg::AXIS_W-1:0]};
  assign cur_dim  = dim_q[entry];
  assign cur_cnt  = count_q[slot_q];

  // Launch a division when a used axis is reached.
  assign chain[0] = '{valid: (state_q == svim_pkg::ST_AXIS) && (ax_q != '0) && (cur_dim != '0),
                      rem:   '0,
                      quo:   idx_q,
                      dvs:   cur_dim};

  for (genvar g = 0; g < svim_pkg::DIV_STEPS; g++) begin : g_cell
    svim_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= svim_pkg::DIV_STEPS; g++) begin : g_vld
    assign chain_valid[g] = chain[g].valid;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      svim_pkg::ST_IDLE: begin
        if (in_hs && (in_i.action == svim_pkg::ACT_MAP)) state_d = svim_pkg::ST_VIEW;
      end
      svim_pkg::ST_VIEW: begin
        state_d = contig_q[slot_q] ? svim_pkg::ST_NEXT : svim_pkg::ST_AXIS;
      end
      svim_pkg::ST_AXIS: begin
        if (ax_q == '0) state_d = svim_pkg::ST_NEXT;
        else if (cur_dim != '0) state_d = svim_pkg::ST_DIV;
      end
      svim_pkg::ST_DIV: begin
        if (chain[svim_pkg::DIV_STEPS].valid) state_d = svim_pkg::ST_MUL;
      end
      svim_pkg::ST_MUL: state_d = svim_pkg::ST_ACC;
      svim_pkg::ST_ACC: state_d = svim_pkg::ST_AXIS;
      svim_pkg::ST_NEXT: begin
        if (slot_q != pvc_q) state_d = svim_pkg::ST_VIEW;
        else if (out_free) state_d = svim_pkg::ST_IDLE;
      end
      default: state_d = svim_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svim_pkg::ST_IDLE;
      pvc_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < svim_pkg::MAX_VIEWS; i++) begin
        contig_q[i] <= 1'b0;
        count_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) pvc_q <= cfg_i.data;
      if (in_hs && (in_i.action == svim_pkg::ACT_VIEW)) begin
        contig_q[in_i.view_slot[svim_pkg::SLOT_W-1:0]] <= in_i.contiguous_value;
        count_q[in_i.view_slot[svim_pkg::SLOT_W-1:0]]  <= in_i.axis_total;
      end
      if (state_q == svim_pkg::ST_NEXT && slot_q == pvc_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs && (in_i.action == svim_pkg::ACT_AXIS)) begin
      dim_q[wr_entry]    <= in_i.dim_value;
      stride_q[wr_entry] <= $unsigned(in_i.stride_value);
    end
    if (in_hs && (in_i.action == svim_pkg::ACT_VIEW)) begin
      offset_q[in_i.view_slot[svim_pkg::SLOT_W-1:0]] <= $unsigned(in_i.offset_value);
    end
    case (state_q)
      svim_pkg::ST_IDLE: begin
        idx_q  <= in_i.flat_index;
        slot_q <= '0;
      end
      svim_pkg::ST_VIEW: begin
        // Clamp the axis count to the table depth.
        ax_q  <= (cur_cnt > 3'(svim_pkg::MAX_AXES)) ? (svim_pkg::AXIS_W+1)'(svim_pkg::MAX_AXES)
                                                     : (svim_pkg::AXIS_W+1)'(cur_cnt);
        if (contig_q[slot_q]) acc_q <= idx_q + offset_q[slot_q];
        else acc_q <= offset_q[slot_q];
      end
      svim_pkg::ST_AXIS: begin
        strd_q <= stride_q[entry];
        if (ax_q != '0 && cur_dim == '0) ax_q <= ax_m1;
      end
      svim_pkg::ST_DIV: begin
        if (chain[svim_pkg::DIV_STEPS].valid) begin
          idx_q   <= chain[svim_pkg::DIV_STEPS].quo;
          coord_q <= chain[svim_pkg::DIV_STEPS].rem;
        end
      end
      svim_pkg::ST_MUL: prod_q <= coord_q * strd_q;
      svim_pkg::ST_ACC: begin
        acc_q <= acc_q + prod_q;
        ax_q  <= ax_m1;
      end
      svim_pkg::ST_NEXT: begin
        // Feed this view's result to the next slot or hand it out.
        if (slot_q != pvc_q) begin
          idx_q  <= acc_q;
          slot_q <= slot_q + 1'b1;
        end else if (out_free) begin
          res_q <= acc_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.buffer_index = res_q;

  a_div_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_valid) <= 1)
    else $error("more than one division in flight");

  a_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[svim_pkg::DIV_STEPS].valid |-> state_q == svim_pkg::ST_DIV)
    else $error("quotient arrived outside the wait state");

  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svim_pkg::ST_NEXT && slot_q == pvc_q && out_free) |=> out_valid_q)
    else $error("finished map did not produce a result");

endmodule
